// ----- rtl/core/dlpp_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants of the directory listing page parser.
// No dependencies; the files that use it refer to it by scoped names.
package dlpp_pkg;

   localparam int NameChars  = 16;
   localparam int NameLenW   = $clog2(NameChars + 1);
   localparam int NameIdxW   = (NameChars > 1) ? $clog2(NameChars) : 1;
   localparam int QueueDepth = 2;
   localparam int QueuePtrW  = $clog2(QueueDepth);

   // configuration register indexes
   localparam logic [1:0] CsrStartIndex = 2'd0;
   localparam logic [1:0] CsrPageLimit  = 2'd1;
   localparam logic [1:0] CsrTypeFilter = 2'd2;

   // file type codes
   localparam logic [2:0] TypeDel   = 3'd0;
   localparam logic [2:0] TypeSeq   = 3'd1;
   localparam logic [2:0] TypePrg   = 3'd2;
   localparam logic [2:0] TypeUsr   = 3'd3;
   localparam logic [2:0] TypeRel   = 3'd4;
   localparam logic [2:0] TypeCbm   = 3'd5;
   localparam logic [2:0] TypeDir   = 3'd6;
   localparam logic [2:0] FilterAny = 3'd7;

   // result kinds
   localparam logic KindChar = 1'b0;
   localparam logic KindDone = 1'b1;

   localparam logic [7:0] CharNul   = 8'h00;
   localparam logic [7:0] CharQuote = 8'h22;
   localparam logic [7:0] CharSpace = 8'h20;
   localparam logic [7:0] CharShSp  = 8'hA0;
   localparam logic [7:0] CountMax  = 8'hFF;

   typedef struct packed {
      logic [7:0] first_index;
      logic [7:0] page_limit;
      logic [2:0] type_filter;
   } cfg_type;

   // one unit of work for the back end: an optional name run, then an optional summary
   typedef struct packed {
      logic                           has_name;
      logic                           has_done;
      logic [NameChars-1:0][7:0]      name;
      logic [NameLenW-1:0]            name_len;
      logic [2:0]                     file_type;
      logic [7:0]                     entry_slot;
      logic [7:0]                     page_count;
      logic [7:0]                     match_count;
   } job_type;

endpackage

// ----- rtl/core/dlpp_req_if.sv -----
`timescale 1ns / 1ps
// Input byte channel of the directory listing page parser.
// Carries valid, ready and one listing byte per transfer.
interface dlpp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] stream_byte;
   logic       end_of_stream;

   modport source (output valid, output stream_byte, output end_of_stream, input ready);
   modport sink   (input valid, input stream_byte, input end_of_stream, output ready);
endinterface

// ----- rtl/core/dlpp_rsp_if.sv -----
`timescale 1ns / 1ps
// Result channel of the directory listing page parser.
// Carries valid, ready and one name character or done summary per transfer.
interface dlpp_rsp_if;
   logic       valid;
   logic       ready;
   logic       result_kind;
   logic [7:0] name_char;
   logic [3:0] char_position;
   logic [2:0] file_type;
   logic [7:0] entry_slot;
   logic       last_of_run;
   logic [7:0] page_count;
   logic [7:0] match_count;

   modport source (output valid, output result_kind, output name_char, output char_position,
                   output file_type, output entry_slot, output last_of_run,
                   output page_count, output match_count, input ready);
   modport sink   (input valid, input result_kind, input name_char, input char_position,
                   input file_type, input entry_slot, input last_of_run,
                   input page_count, input match_count, output ready);
endinterface

// ----- rtl/core/dlpp_front.sv -----
`timescale 1ns / 1ps
// Front end: takes listing bytes, tracks the line structure and builds at most one
// job per byte that ends an entry or the listing. Depends on dlpp_pkg and dlpp_req_if.
module dlpp_front (
   input  logic               clock,
   input  logic               reset,
   input  dlpp_pkg::cfg_type  cfg,
   dlpp_req_if.sink           req_if,
   input  logic               queue_full,
   output logic               job_push,
   output dlpp_pkg::job_type  job
);

   localparam logic [2:0] PhLoad = 3'd0;
   localparam logic [2:0] PhLink = 3'd1;
   localparam logic [2:0] PhNum  = 3'd2;
   localparam logic [2:0] PhName = 3'd3;
   localparam logic [2:0] PhType = 3'd4;
   localparam logic [2:0] PhDone = 3'd5;

   logic [2:0]                            phase_ff, phase_in;
   logic                                  hcnt_ff, hcnt_in;
   logic                                  lz_ff, lz_in;
   logic                                  inq_ff, inq_in;
   logic [dlpp_pkg::NameLenW-1:0]         nlen_ff, nlen_in;
   logic [dlpp_pkg::NameChars-1:0][7:0]   name_ff, name_in;
   logic [2:0][7:0]                       tlet_ff, tlet_in;
   logic [1:0]                            tlen_ff, tlen_in;
   logic                                  hdr_ff, hdr_in;
   logic [7:0]                            emit_ff, emit_in;
   logic [7:0]                            match_ff, match_in;

   logic       accept;
   logic [7:0] b;
   logic       eos;
   logic       do_end;
   logic       do_finish;
   logic [2:0] ty;
   logic [7:0] bound;

   function automatic logic [7:0] fold(input logic [7:0] c);
      logic [7:0] f;
      f = {1'b0, c[6:0]};
      if (f >= "a" && f <= "z") f = f - 8'h20;
      return f;
   endfunction

   function automatic logic [2:0] classify(input logic [2:0][7:0] l, input logic [1:0] n);
      logic [23:0] w;
      logic [2:0]  r;
      w = {fold(l[0]), fold(l[1]), fold(l[2])};
      r = dlpp_pkg::TypeDel;
      if (n == 2'd3) begin
         unique if (w == "SEQ") r = dlpp_pkg::TypeSeq;
         else if (w == "PRG") r = dlpp_pkg::TypePrg;
         else if (w == "USR") r = dlpp_pkg::TypeUsr;
         else if (w == "REL") r = dlpp_pkg::TypeRel;
         else if (w == "DIR") r = dlpp_pkg::TypeDir;
         else if (w == "CBM") r = dlpp_pkg::TypeCbm;
         else r = dlpp_pkg::TypeDel;
      end
      return r;
   endfunction

   assign req_if.ready = !queue_full;
   assign accept       = req_if.valid && !queue_full;
   assign b            = req_if.stream_byte;
   assign eos          = req_if.end_of_stream;
   assign bound        = cfg.first_index + cfg.page_limit;

   always_comb begin
      phase_in  = phase_ff;
      hcnt_in   = hcnt_ff;
      lz_in     = lz_ff;
      inq_in    = inq_ff;
      nlen_in   = nlen_ff;
      name_in   = name_ff;
      tlet_in   = tlet_ff;
      tlen_in   = tlen_ff;
      hdr_in    = hdr_ff;
      emit_in   = emit_ff;
      match_in  = match_ff;
      do_end    = 1'b0;
      do_finish = 1'b0;
      ty        = dlpp_pkg::TypeDel;
      job       = '0;

      if (accept && phase_ff != PhDone) begin
         unique case (phase_ff)
            PhLoad: begin
               if (hcnt_ff) begin
                  hcnt_in  = 1'b0;
                  phase_in = PhLink;
               end else begin
                  hcnt_in = 1'b1;
               end
            end
            PhLink: begin
               lz_in = (b == 8'd0) && (!hcnt_ff || lz_ff);
               if (hcnt_ff) begin
                  hcnt_in  = 1'b0;
                  phase_in = PhNum;
               end else begin
                  hcnt_in = 1'b1;
               end
            end
            PhNum: begin
               if (hcnt_ff) begin
                  hcnt_in = 1'b0;
                  if (lz_ff) begin
                     do_finish = 1'b1;
                  end else begin
                     phase_in = PhName;
                     inq_in   = 1'b0;
                     nlen_in  = '0;
                     tlen_in  = 2'd0;
                  end
               end else begin
                  hcnt_in = 1'b1;
               end
            end
            PhName: begin
               if (b == dlpp_pkg::CharNul) begin
                  do_end = 1'b1;
               end else if (b == dlpp_pkg::CharQuote) begin
                  if (inq_ff) phase_in = PhType;
                  else inq_in = 1'b1;
               end else if (inq_ff && nlen_ff < dlpp_pkg::NameLenW'(dlpp_pkg::NameChars)) begin
                  name_in[nlen_ff[dlpp_pkg::NameIdxW-1:0]] = b;
                  nlen_in = nlen_ff + dlpp_pkg::NameLenW'(1);
               end
            end
            PhType: begin
               if (b == dlpp_pkg::CharNul) begin
                  do_end = 1'b1;
               end else if (b != dlpp_pkg::CharSpace && b != dlpp_pkg::CharShSp
                            && tlen_ff != 2'd3) begin
                  tlet_in[tlen_ff] = b;
                  tlen_in = tlen_ff + 2'd1;
               end
            end
            default: ;
         endcase

         // a stream that stops mid-line closes the line first
         if (eos && (phase_ff == PhName || phase_ff == PhType)) do_end = 1'b1;

         if (do_end) begin
            phase_in = PhLink;
            hcnt_in  = 1'b0;
            if (hdr_ff) begin
               hdr_in = 1'b0;
            end else if (nlen_in != '0) begin
               ty = classify(tlet_in, tlen_in);
               if (cfg.type_filter == dlpp_pkg::FilterAny || cfg.type_filter == ty) begin
                  if (match_ff >= cfg.first_index && emit_ff < cfg.page_limit) begin
                     job.has_name   = 1'b1;
                     job.name       = name_in;
                     job.name_len   = nlen_in;
                     job.file_type  = ty;
                     job.entry_slot = emit_ff;
                     emit_in        = emit_ff + 8'd1;
                  end
                  if (match_ff != dlpp_pkg::CountMax) match_in = match_ff + 8'd1;
                  if (match_in > bound) do_finish = 1'b1;
               end
            end
         end

         if (eos) do_finish = 1'b1;

         if (do_finish) begin
            job.has_done    = 1'b1;
            job.page_count  = emit_in;
            job.match_count = match_in;
            phase_in        = PhDone;
         end
      end

      // rearm for the next listing
      if (accept && eos) begin
         phase_in = PhLoad;
         hcnt_in  = 1'b0;
         lz_in    = 1'b0;
         inq_in   = 1'b0;
         nlen_in  = '0;
         tlen_in  = 2'd0;
         hdr_in   = 1'b1;
         emit_in  = 8'd0;
         match_in = 8'd0;
      end
   end

   assign job_push = accept && (job.has_name || job.has_done);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PhLoad;
         hcnt_ff  <= 1'b0;
         lz_ff    <= 1'b0;
         inq_ff   <= 1'b0;
         nlen_ff  <= '0;
         tlen_ff  <= 2'd0;
         hdr_ff   <= 1'b1;
         emit_ff  <= 8'd0;
         match_ff <= 8'd0;
      end else begin
         phase_ff <= phase_in;
         hcnt_ff  <= hcnt_in;
         lz_ff    <= lz_in;
         inq_ff   <= inq_in;
         nlen_ff  <= nlen_in;
         tlen_ff  <= tlen_in;
         hdr_ff   <= hdr_in;
         emit_ff  <= emit_in;
         match_ff <= match_in;
      end
   end

   always_ff @(posedge clock) begin
      name_ff <= name_in;
      tlet_ff <= tlet_in;
   end

endmodule

// ----- rtl/core/dlpp_queue.sv -----
`timescale 1ns / 1ps
// Two-entry job queue between the front and back ends.
// Depends on dlpp_pkg for the job type and depth.
module dlpp_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  dlpp_pkg::job_type  push_job,
   input  logic               pop,
   output logic               full,
   output logic               not_empty,
   output dlpp_pkg::job_type  head_job
);

   localparam int CountW = $clog2(dlpp_pkg::QueueDepth + 1);

   dlpp_pkg::job_type                entry_ff [dlpp_pkg::QueueDepth];
   logic [dlpp_pkg::QueuePtrW-1:0]   wptr_ff, wptr_in;
   logic [dlpp_pkg::QueuePtrW-1:0]   rptr_ff, rptr_in;
   logic [CountW-1:0]                count_ff, count_in;
   logic                             do_push, do_pop;

   assign full      = count_ff == CountW'(dlpp_pkg::QueueDepth);
   assign not_empty = count_ff != '0;
   assign head_job  = entry_ff[rptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wptr_in  = do_push ? wptr_ff + dlpp_pkg::QueuePtrW'(1) : wptr_ff;
      rptr_in  = do_pop  ? rptr_ff + dlpp_pkg::QueuePtrW'(1) : rptr_ff;
      count_in = count_ff;
      if (do_push && !do_pop) count_in = count_ff + CountW'(1);
      else if (!do_push && do_pop) count_in = count_ff - CountW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wptr_ff] <= push_job;
   end

endmodule

// ----- rtl/core/dlpp_back.sv -----
`timescale 1ns / 1ps
// Back end: takes jobs from the queue and plays them out as name characters and a
// done summary through an output register. Depends on dlpp_pkg and dlpp_rsp_if.
module dlpp_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               job_valid,
   input  dlpp_pkg::job_type  job,
   output logic               job_pop,
   dlpp_rsp_if.source         rsp_if
);

   dlpp_pkg::job_type               job_ff, job_in;
   logic                            busy_ff, busy_in;
   logic                            name_pend_ff, name_pend_in;
   logic                            done_pend_ff, done_pend_in;
   logic [dlpp_pkg::NameIdxW-1:0]   pos_ff, pos_in;
   logic                            out_free;
   logic                            emit;
   logic                            last;

   logic       valid_ff, valid_in;
   logic       kind_ff, kind_in;
   logic [7:0] char_ff, char_in;
   logic [3:0] cpos_ff, cpos_in;
   logic [2:0] type_ff, type_in;
   logic [7:0] slot_ff, slot_in;
   logic       last_ff, last_in;
   logic [7:0] page_ff, page_in;
   logic [7:0] total_ff, total_in;

   assign out_free = !valid_ff || rsp_if.ready;
   assign job_pop  = !busy_ff && job_valid;
   assign emit     = busy_ff && out_free;
   assign last     = dlpp_pkg::NameLenW'(pos_ff) == job_ff.name_len - dlpp_pkg::NameLenW'(1);

   always_comb begin
      job_in       = job_ff;
      busy_in      = busy_ff;
      name_pend_in = name_pend_ff;
      done_pend_in = done_pend_ff;
      pos_in       = pos_ff;
      valid_in     = out_free ? 1'b0 : valid_ff;
      kind_in      = kind_ff;
      char_in      = char_ff;
      cpos_in      = cpos_ff;
      type_in      = type_ff;
      slot_in      = slot_ff;
      last_in      = last_ff;
      page_in      = page_ff;
      total_in     = total_ff;

      if (job_pop) begin
         job_in       = job;
         busy_in      = 1'b1;
         name_pend_in = job.has_name;
         done_pend_in = job.has_done;
         pos_in       = '0;
      end else if (emit) begin
         valid_in = 1'b1;
         if (name_pend_ff) begin
            kind_in  = dlpp_pkg::KindChar;
            char_in  = job_ff.name[pos_ff];
            cpos_in  = 4'(pos_ff);
            type_in  = job_ff.file_type;
            slot_in  = job_ff.entry_slot;
            last_in  = last;
            page_in  = 8'd0;
            total_in = 8'd0;
            if (last) begin
               name_pend_in = 1'b0;
               if (!done_pend_ff) busy_in = 1'b0;
            end else begin
               pos_in = pos_ff + dlpp_pkg::NameIdxW'(1);
            end
         end else begin
            kind_in      = dlpp_pkg::KindDone;
            char_in      = 8'd0;
            cpos_in      = 4'd0;
            type_in      = 3'd0;
            slot_in      = 8'd0;
            last_in      = 1'b1;
            page_in      = job_ff.page_count;
            total_in     = job_ff.match_count;
            done_pend_in = 1'b0;
            busy_in      = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         name_pend_ff <= 1'b0;
         done_pend_ff <= 1'b0;
         valid_ff     <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         name_pend_ff <= name_pend_in;
         done_pend_ff <= done_pend_in;
         valid_ff     <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff   <= job_in;
      pos_ff   <= pos_in;
      kind_ff  <= kind_in;
      char_ff  <= char_in;
      cpos_ff  <= cpos_in;
      type_ff  <= type_in;
      slot_ff  <= slot_in;
      last_ff  <= last_in;
      page_ff  <= page_in;
      total_ff <= total_in;
   end

   assign rsp_if.valid         = valid_ff;
   assign rsp_if.result_kind   = kind_ff;
   assign rsp_if.name_char     = char_ff;
   assign rsp_if.char_position = cpos_ff;
   assign rsp_if.file_type     = type_ff;
   assign rsp_if.entry_slot    = slot_ff;
   assign rsp_if.last_of_run   = last_ff;
   assign rsp_if.page_count    = page_ff;
   assign rsp_if.match_count   = total_ff;

endmodule

// ----- rtl/core/directory_listing_page_parser_unit.sv -----
`timescale 1ns / 1ps
// Directory listing page parser: top level with the configuration registers.
// Depends on dlpp_pkg, dlpp_req_if, dlpp_rsp_if, dlpp_front, dlpp_queue, dlpp_back.
//
// Usage:
//   req_if carries one listing byte per transfer, with end_of_stream on the last one.
//   rsp_if carries name characters of the entries in the page window, one per
//   transfer, and a done summary with the page and match counts.
//   csr_* writes the first index, page limit and type filter; write only while idle.
// Timing:
//   A byte is taken every cycle while the two-entry job queue has room. The front
//   end forms each job combinationally; a byte that closes an entry or the
//   listing queues at most one job, held in the queue entry, then the back end job
//   register, then the output register. A run gives one character per cycle while
//   rsp_if is ready, pausing between jobs while the back end loads the next one.
// Reset: registers return to start 0, limit 8, filter any; the parser waits for
//   the load address and the queue is empty.
// Stall: a stalled receiver holds the output register; the back end stops, the
//   queue fills and then ready drops on req_if.
module directory_listing_page_parser_unit (
   input  logic        clock,
   input  logic        reset,
   dlpp_req_if.sink    req_if,
   dlpp_rsp_if.source  rsp_if,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_write_data
);

   dlpp_pkg::cfg_type cfg_ff, cfg_in;
   dlpp_pkg::job_type push_job, head_job;
   logic              push, pop, full, not_empty;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            dlpp_pkg::CsrStartIndex: cfg_in.first_index = csr_write_data;
            dlpp_pkg::CsrPageLimit:  cfg_in.page_limit  = csr_write_data;
            dlpp_pkg::CsrTypeFilter: cfg_in.type_filter = csr_write_data[2:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.first_index <= 8'd0;
         cfg_ff.page_limit  <= 8'd8;
         cfg_ff.type_filter <= dlpp_pkg::FilterAny;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   dlpp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_if     (req_if),
      .queue_full (full),
      .job_push   (push),
      .job        (push_job)
   );

   dlpp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_job  (push_job),
      .pop       (pop),
      .full      (full),
      .not_empty (not_empty),
      .head_job  (head_job)
   );

   dlpp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (not_empty),
      .job       (head_job),
      .job_pop   (pop),
      .rsp_if    (rsp_if)
   );

endmodule

// ----- tb/directory_listing_page_parser_unit_tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for the directory listing page parser: a short table of listing bytes,
// then random listings under changing page windows and filters, with random stalls.
// Depends on dlpp_pkg, dlpp_req_if, dlpp_rsp_if and directory_listing_page_parser_unit.
module directory_listing_page_parser_unit_tb;

   localparam int HoldOffCycles = 400;
   localparam int StallLimit    = 3000;
   localparam int SettleCycles  = 10;
   localparam int PressureBytes = 8;

   typedef enum logic [2:0] {
      ScanLoad, ScanLink, ScanNumber, ScanName, ScanType, ScanDone
   } scan_phase_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] ch;
      logic [3:0] pos;
      logic [2:0] ety;
      logic [7:0] slot;
      logic       last;
      logic [7:0] pc;
      logic [7:0] tc;
   } listing_result_type;

   typedef struct packed {
      logic [7:0] data;
      logic       eos;
      logic       typed;
      logic [7:0] pc;
      logic [7:0] tc;
   } stim_row_type;

   localparam logic [23:0] TypeText [7] = '{"DEL", "SEQ", "PRG", "USR", "REL", "CBM", "DIR"};

   // reset config: start 0, limit 8, any type
   localparam stim_row_type DirectedRows [27] = '{
      '{8'h00, 1'b1, 1'b1, 8'd0, 8'd0},   // end of stream inside the load address
      '{8'hFF, 1'b0, 1'b0, 8'd0, 8'd0},
      '{8'hFF, 1'b0, 1'b0, 8'd0, 8'd0},
      '{8'h01, 1'b0, 1'b0, 8'd0, 8'd0},
      '{8'h00, 1'b0, 1'b0, 8'd0, 8'd0},
      '{8'h00, 1'b0, 1'b0, 8'd0, 8'd0},
      '{8'h00, 1'b0, 1'b0, 8'd0, 8'd0},
      '{8'h00, 1'b0, 1'b0, 8'd0, 8'd0},   // nameless header line
      '{8'h01, 1'b0, 1'b0, 8'd0, 8'd0},
      '{8'h08, 1'b0, 1'b0, 8'd0, 8'd0},
      '{8'hFF, 1'b0, 1'b0, 8'd0, 8'd0},
      '{8'hFF, 1'b0, 1'b0, 8'd0, 8'd0},
      '{8'h22, 1'b0, 1'b0, 8'd0, 8'd0},
      '{8'h61, 1'b0, 1'b0, 8'd0, 8'd0},
      '{8'h22, 1'b0, 1'b0, 8'd0, 8'd0},
      '{8'hA0, 1'b0, 1'b0, 8'd0, 8'd0},
      '{8'h20, 1'b0, 1'b0, 8'd0, 8'd0},
      '{8'h70, 1'b0, 1'b0, 8'd0, 8'd0},   // lower case and bit 7 set in the type letters
      '{8'hD2, 1'b0, 1'b0, 8'd0, 8'd0},
      '{8'h67, 1'b1, 1'b0, 8'd0, 8'd0},   // stream ends inside the line
      '{8'h00, 1'b0, 1'b0, 8'd0, 8'd0},
      '{8'h00, 1'b0, 1'b0, 8'd0, 8'd0},
      '{8'h00, 1'b0, 1'b0, 8'd0, 8'd0},
      '{8'h00, 1'b0, 1'b0, 8'd0, 8'd0},
      '{8'h12, 1'b0, 1'b0, 8'd0, 8'd0},
      '{8'h34, 1'b0, 1'b1, 8'd0, 8'd0},   // zero link ends the listing
      '{8'h7F, 1'b1, 1'b0, 8'd0, 8'd0}    // ignored after done, rearms
   };

   logic       clock = 1'b0;
   logic       reset;
   logic       csr_write_enable;
   logic [1:0] csr_index;
   logic [7:0] csr_write_data;

   dlpp_req_if req_if ();
   dlpp_rsp_if rsp_if ();

   directory_listing_page_parser_unit i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_if           (req_if),
      .rsp_if           (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // parser copy
   logic [7:0]     cfg_start, cfg_limit;
   logic [2:0]     cfg_filter;
   scan_phase_type scan_phase;
   int             word_bytes;
   logic           link_is_zero, quote_open, header_pending, listing_over;
   logic [7:0]     name_buf [dlpp_pkg::NameChars];
   int             name_len;
   logic [7:0]     type_buf [3];
   int             type_len;
   logic [7:0]     emitted, matched;

   listing_result_type pending_results [$];
   listing_result_type oldest_result;
   logic [7:0]         listing_bytes [$];

   int error_count = 0;
   int sent_items = 0;
   int stall_cycles = 0;
   bit quiet_tail = 1'b0;
   bit hold_off_request = 1'b0;
   bit holding_off = 1'b0;

   function automatic logic [7:0] rand_byte();
      return 8'($urandom);
   endfunction

   // any byte that neither ends a line nor toggles the quotes
   function automatic logic [7:0] name_byte();
      logic [7:0] b;
      do b = rand_byte(); while (b == dlpp_pkg::CharNul || b == dlpp_pkg::CharQuote);
      return b;
   endfunction

   function automatic listing_result_type make_result(logic kind, logic [7:0] ch,
                                                       logic [3:0] pos, logic [2:0] ety,
                                                       logic [7:0] slot, logic last,
                                                       logic [7:0] pc, logic [7:0] tc);
      listing_result_type r;
      r.kind = kind;
      r.ch   = ch;
      r.pos  = pos;
      r.ety  = ety;
      r.slot = slot;
      r.last = last;
      r.pc   = pc;
      r.tc   = tc;
      return r;
   endfunction

   function automatic logic [7:0] fold_letter(logic [7:0] c);
      logic [7:0] f;
      f = {1'b0, c[6:0]};
      if (f >= "a" && f <= "z") begin
         f = f - 8'h20;
      end
      return f;
   endfunction

   function automatic logic [2:0] entry_class();
      logic [23:0] key;
      if (type_len < 3) return dlpp_pkg::TypeDel;
      key = {fold_letter(type_buf[0]), fold_letter(type_buf[1]), fold_letter(type_buf[2])};
      case (key)
         "SEQ": return dlpp_pkg::TypeSeq;
         "PRG": return dlpp_pkg::TypePrg;
         "USR": return dlpp_pkg::TypeUsr;
         "REL": return dlpp_pkg::TypeRel;
         "CBM": return dlpp_pkg::TypeCbm;
         "DIR": return dlpp_pkg::TypeDir;
         default: return dlpp_pkg::TypeDel;
      endcase
   endfunction

   task automatic rearm_listing();
      scan_phase     = ScanLoad;
      word_bytes     = 0;
      link_is_zero   = 1'b0;
      quote_open     = 1'b0;
      name_len       = 0;
      type_len       = 0;
      header_pending = 1'b1;
      emitted        = 8'h00;
      matched        = 8'h00;
      listing_over   = 1'b0;
   endtask

   task automatic close_listing();
      pending_results.push_back(make_result(dlpp_pkg::KindDone, 8'h00, 4'h0,
                                            dlpp_pkg::TypeDel, 8'h00, 1'b1,
                                            emitted, matched));
      listing_over = 1'b1;
      scan_phase   = ScanDone;
   endtask

   task automatic close_line();
      logic [2:0] ty;
      logic [7:0] bound;
      scan_phase = ScanLink;
      word_bytes = 0;
      if (header_pending) begin
         header_pending = 1'b0;
         return;
      end
      if (name_len == 0) return;
      ty = entry_class();
      if (cfg_filter != dlpp_pkg::FilterAny && cfg_filter != ty) return;
      if (matched >= cfg_start && emitted < cfg_limit) begin
         for (int i = 0; i < name_len; i++) begin
            pending_results.push_back(make_result(dlpp_pkg::KindChar, name_buf[i], 4'(i),
                                                  ty, emitted, (i == name_len - 1),
                                                  8'h00, 8'h00));
         end
         emitted = emitted + 8'd1;
      end
      if (matched != dlpp_pkg::CountMax) matched = matched + 8'd1;
      bound = cfg_start + cfg_limit;
      if (matched > bound) close_listing();
   endtask

   task automatic parse_byte(input logic [7:0] b, input logic eos);
      if (!listing_over) begin
         case (scan_phase)
            ScanLoad: begin
               word_bytes++;
               if (word_bytes >= 2) begin
                  word_bytes = 0;
                  scan_phase = ScanLink;
               end
            end
            ScanLink: begin
               if (word_bytes == 0) link_is_zero = (b == 8'h00);
               else link_is_zero = link_is_zero && (b == 8'h00);
               word_bytes++;
               if (word_bytes >= 2) begin
                  word_bytes = 0;
                  scan_phase = ScanNumber;
               end
            end
            ScanNumber: begin
               word_bytes++;
               if (word_bytes >= 2) begin
                  word_bytes = 0;
                  if (link_is_zero) begin
                     close_listing();
                  end else begin
                     scan_phase = ScanName;
                     quote_open = 1'b0;
                     name_len   = 0;
                     type_len   = 0;
                  end
               end
            end
            ScanName: begin
               if (b == dlpp_pkg::CharNul) begin
                  close_line();
               end else if (b == dlpp_pkg::CharQuote) begin
                  if (quote_open) scan_phase = ScanType;
                  else quote_open = 1'b1;
               end else if (quote_open && name_len < dlpp_pkg::NameChars) begin
                  name_buf[name_len] = b;
                  name_len++;
               end
            end
            ScanType: begin
               if (b == dlpp_pkg::CharNul) begin
                  close_line();
               end else if (b != dlpp_pkg::CharSpace && b != dlpp_pkg::CharShSp
                            && type_len < 3) begin
                  type_buf[type_len] = b;
                  type_len++;
               end
            end
            default: ;
         endcase
         // a partial line is closed as if a zero byte had come
         if (eos && !listing_over) begin
            if (scan_phase == ScanName || scan_phase == ScanType) close_line();
            if (!listing_over) close_listing();
         end
      end
      if (eos) rearm_listing();
   endtask

   task automatic send_byte(input logic [7:0] b, input logic eos, input logic typed,
                            input logic [7:0] pc, input logic [7:0] tc);
      req_if.valid         <= 1'b1;
      req_if.stream_byte   <= b;
      req_if.end_of_stream <= eos;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      parse_byte(b, eos);
      if (typed && pending_results.size() != 0) begin
         void'(pending_results.pop_back());
         pending_results.push_back(make_result(dlpp_pkg::KindDone, 8'h00, 4'h0,
                                               dlpp_pkg::TypeDel, 8'h00, 1'b1, pc, tc));
      end
      sent_items++;
      if (!quiet_tail && $urandom_range(0, 7) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
   endtask

   // drop valid, drain, then let any result-free bytes clear the pipeline
   task automatic settle_block();
      req_if.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_config(input logic [7:0] s, input logic [7:0] l, input logic [2:0] f);
      logic [7:0] filter_word;
      filter_word      = rand_byte();
      filter_word[2:0] = f;
      csr_write_enable <= 1'b1;
      csr_index        <= dlpp_pkg::CsrStartIndex;
      csr_write_data   <= s;
      @(posedge clock);
      cfg_start        = s;
      csr_index        <= dlpp_pkg::CsrPageLimit;
      csr_write_data   <= l;
      @(posedge clock);
      cfg_limit        = l;
      csr_index        <= dlpp_pkg::CsrTypeFilter;
      csr_write_data   <= filter_word;
      @(posedge clock);
      cfg_filter       = f;
      csr_write_enable <= 1'b0;
   endtask

   task automatic push_line_head(input bit zero_link);
      logic [7:0] lo, hi;
      lo = rand_byte();
      hi = rand_byte();
      if (zero_link) begin
         lo = 8'h00;
         hi = 8'h00;
      end else if (lo == 8'h00 && hi == 8'h00) begin
         lo = 8'h01;
      end
      listing_bytes.push_back(lo);
      listing_bytes.push_back(hi);
      listing_bytes.push_back(rand_byte());
      listing_bytes.push_back(rand_byte());
   endtask

   task automatic build_listing(input bit allow_faults);
      int         n, k, kind;
      logic [7:0] letter;
      listing_bytes.delete();
      if (allow_faults && $urandom_range(0, 9) == 0) begin
         repeat ($urandom_range(1, 24)) listing_bytes.push_back(rand_byte());
         return;
      end
      listing_bytes.push_back(rand_byte());
      listing_bytes.push_back(rand_byte());
      // header line: disk name and id
      push_line_head(1'b0);
      listing_bytes.push_back(dlpp_pkg::CharQuote);
      repeat ($urandom_range(0, 16)) listing_bytes.push_back(name_byte());
      listing_bytes.push_back(dlpp_pkg::CharQuote);
      listing_bytes.push_back(dlpp_pkg::CharSpace);
      listing_bytes.push_back(name_byte());
      listing_bytes.push_back(name_byte());
      listing_bytes.push_back(8'h00);
      repeat ($urandom_range(0, 6)) begin
         push_line_head(1'b0);
         repeat ($urandom_range(0, 3)) listing_bytes.push_back(dlpp_pkg::CharSpace);
         if ($urandom_range(0, 19) != 0) begin
            listing_bytes.push_back(dlpp_pkg::CharQuote);
            n = $urandom_range(0, 19);
            n = (n == 0) ? 0 : (n < 16) ? $urandom_range(1, 8) : $urandom_range(9, 20);
            repeat (n) listing_bytes.push_back(name_byte());
            if ($urandom_range(0, 9) != 0) listing_bytes.push_back(dlpp_pkg::CharQuote);
         end
         repeat ($urandom_range(0, 4)) begin
            listing_bytes.push_back($urandom_range(0, 1) ? dlpp_pkg::CharSpace
                                                         : dlpp_pkg::CharShSp);
         end
         // 0..6 a known type, 7 garbage letters, 8 too few letters, 9 none
         kind = $urandom_range(0, 9);
         if (kind == 7) begin
            repeat (3) listing_bytes.push_back(name_byte());
         end else if (kind < 9) begin
            k = (kind == 8) ? $urandom_range(0, 6) : kind;
            n = (kind == 8) ? $urandom_range(1, 2) : 3;
            for (int j = 0; j < n; j++) begin
               letter = TypeText[k][23 - 8 * j -: 8];
               if ($urandom_range(0, 1)) letter = letter | 8'h20;
               if ($urandom_range(0, 3) == 0) letter = letter | 8'h80;
               listing_bytes.push_back(letter);
            end
         end
         repeat ($urandom_range(0, 2)) listing_bytes.push_back(name_byte());
         listing_bytes.push_back(8'h00);
      end
      push_line_head(1'b1);
      repeat ($urandom_range(0, 3)) listing_bytes.push_back(rand_byte());
      // cut the stream short at any point
      if (allow_faults && $urandom_range(0, 6) == 0) begin
         n = $urandom_range(1, listing_bytes.size());
         while (listing_bytes.size() > n) void'(listing_bytes.pop_back());
      end
   endtask

   function automatic void check_field(string label, logic [7:0] want_v, logic [7:0] got_v);
      if (want_v !== got_v) begin
         $display("%0t: %s mismatch, expected %h, got %h", $time, label, want_v, got_v);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result, expected none, got kind %0d char %h",
                     $time, rsp_if.result_kind, rsp_if.name_char);
            error_count++;
         end else begin
            oldest_result = pending_results.pop_front();
            check_field("result_kind", oldest_result.kind, rsp_if.result_kind);
            check_field("name_char", oldest_result.ch, rsp_if.name_char);
            check_field("char_position", oldest_result.pos, rsp_if.char_position);
            check_field("file_type", oldest_result.ety, rsp_if.file_type);
            check_field("entry_slot", oldest_result.slot, rsp_if.entry_slot);
            check_field("last_of_run", oldest_result.last, rsp_if.last_of_run);
            check_field("page_count", oldest_result.pc, rsp_if.page_count);
            check_field("match_count", oldest_result.tc, rsp_if.match_count);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid === 1'b1 && req_if.ready === 1'b1)
                || (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= StallLimit) begin
         $display("directory_listing_page_parser_unit_tb: done, errors");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // receiver: random stalls, one long hold-off so the job queue fills
   initial begin
      forever begin
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            holding_off = 1'b1;
            rsp_if.ready <= 1'b0;
            repeat (HoldOffCycles) @(posedge clock);
            holding_off = 1'b0;
         end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            rsp_if.ready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clock);
         end else begin
            rsp_if.ready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge clock);
         end
      end
   end

   initial begin
      int         phase_no, r;
      logic [7:0] s, l;
      logic [2:0] f;
      reset                <= 1'b1;
      req_if.valid         <= 1'b0;
      req_if.stream_byte   <= 8'h00;
      req_if.end_of_stream <= 1'b0;
      csr_write_enable     <= 1'b0;
      csr_index            <= dlpp_pkg::CsrStartIndex;
      csr_write_data       <= 8'h00;
      cfg_start  = 8'd0;
      cfg_limit  = 8'd8;
      cfg_filter = dlpp_pkg::FilterAny;
      rearm_listing();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (DirectedRows[i]) begin
         send_byte(DirectedRows[i].data, DirectedRows[i].eos, DirectedRows[i].typed,
                   DirectedRows[i].pc, DirectedRows[i].tc);
      end

      phase_no = 0;
      while (sent_items < 450 && phase_no < 60) begin
         settle_block();
         case (phase_no)
            0: begin
               s = 8'd0;   l = 8'd255; f = dlpp_pkg::FilterAny;
            end
            1: begin
               s = 8'd255; l = 8'd255; f = dlpp_pkg::FilterAny;
            end
            2: begin
               // bound wraps to 4: stops before the window opens
               s = 8'd250; l = 8'd10;  f = dlpp_pkg::FilterAny;
            end
            3: begin
               s = 8'd1;   l = 8'd0;   f = dlpp_pkg::TypeDel;
            end
            default: begin
               r = $urandom_range(0, 9);
               s = (r < 6) ? 8'($urandom_range(0, 3)) : (r == 6) ? 8'hFF : rand_byte();
               r = $urandom_range(0, 9);
               l = (r == 0) ? 8'h00 : (r == 1) ? 8'hFF : 8'($urandom_range(1, 8));
               f = $urandom_range(0, 1) ? dlpp_pkg::FilterAny : 3'($urandom_range(0, 6));
            end
         endcase
         write_config(s, l, f);
         if (phase_no == 0) begin
            // each one-byte stream queues a summary, so the queue fills behind the hold-off
            hold_off_request = 1'b1;
            wait (holding_off);
            repeat (PressureBytes) send_byte(rand_byte(), 1'b1, 1'b0, 8'h00, 8'h00);
         end
         repeat ($urandom_range(1, 2)) begin
            build_listing(phase_no != 0);
            foreach (listing_bytes[i]) begin
               if (sent_items >= 380) quiet_tail = 1'b1;
               send_byte(listing_bytes[i], (i == listing_bytes.size() - 1), 1'b0,
                         8'h00, 8'h00);
            end
         end
         phase_no++;
      end

      settle_block();
      if (error_count == 0) begin
         $display("directory_listing_page_parser_unit_tb: done, clean");
      end else begin
         $display("directory_listing_page_parser_unit_tb: done, errors");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/core/dlpp_pkg.sv
rtl/core/dlpp_req_if.sv
rtl/core/dlpp_rsp_if.sv
rtl/core/dlpp_front.sv
rtl/core/dlpp_queue.sv
rtl/core/dlpp_back.sv
rtl/core/directory_listing_page_parser_unit.sv
tb/directory_listing_page_parser_unit_tb.sv
